// ===== rtl/core/shidx_pkg.sv =====
// shidx_pkg: shared types and constants of the sparse height index table
// used by sparse_height_index_table_core and tb_top; no dependencies
package shidx_pkg;

  // field widths of an item
  localparam int unsigned HEIGHT_W = 32;
  localparam int unsigned AMOUNT_W = 64;
  localparam int unsigned ID_W     = 64;
  localparam int unsigned ENTRY_W  = HEIGHT_W + AMOUNT_W + ID_W;

  // default number of table entries
  localparam int unsigned TABLE_DEPTH_DEF = 1024;

  typedef enum logic [1:0] {
    MODE_PUSH  = 2'd0,
    MODE_POP   = 2'd1,
    MODE_TRUNC = 2'd2,
    MODE_QUERY = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_POP_EMPTY = 2'd1,
    STAT_FULL      = 2'd2,
    STAT_OVERFLOW  = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_FETCH,
    ST_POP,
    ST_DONE
  } state_e;

endpackage

// ===== rtl/core/shidx_ram.sv =====
// shidx_ram: generic single-port ram with registered read data
// no dependencies
module shidx_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/sparse_height_index_table_core.sv =====
// sparse_height_index_table_core: block counter plus sorted entry table in ram
// depends on shidx_pkg and shidx_ram
//
//  channel | signals                                        | dir
//  --------+------------------------------------------------+-----
//  in      | in_valid_i in_ready_o mode_i height_i          | in
//          | amount_i token_id_i                            |
//  out     | out_valid_o out_ready_i found_amount_o         | out
//          | found_token_id_o block_total_o removed_blocks_o|
//          | status_o                                       |
//
// one item at a time; push goes straight to done, pop reads the last entry,
// query and truncate run a binary search, and a query then fetches the found entry:
// each binary search step is one read of the single-port entry ram.
// items with no ram read (pop or search with no entries, no-op truncate) go to done.
// rst_ni clears the counters and control; the ram contents are not cleared.
// a result waiting in the output register does not block the next item;
// a finished item waits in the done state until the output register frees.
module sparse_height_index_table_core #(
  parameter int unsigned TABLE_DEPTH = shidx_pkg::TABLE_DEPTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [1:0]                    mode_i,
  input  logic [shidx_pkg::HEIGHT_W-1:0] height_i,
  input  logic [shidx_pkg::AMOUNT_W-1:0] amount_i,
  input  logic [shidx_pkg::ID_W-1:0]     token_id_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [shidx_pkg::AMOUNT_W-1:0] found_amount_o,
  output logic [shidx_pkg::ID_W-1:0]     found_token_id_o,
  output logic [shidx_pkg::HEIGHT_W-1:0] block_total_o,
  output logic [shidx_pkg::HEIGHT_W-1:0] removed_blocks_o,
  output logic [1:0]                    status_o
);

  localparam int unsigned IDX_W = $clog2(TABLE_DEPTH);
  localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned HW    = shidx_pkg::HEIGHT_W;
  localparam int unsigned AW    = shidx_pkg::AMOUNT_W;
  localparam int unsigned IW    = shidx_pkg::ID_W;
  localparam int unsigned EW    = shidx_pkg::ENTRY_W;

  shidx_pkg::state_e  state_q, state_d;
  logic               query_q, query_d;
  logic [CNT_W-1:0]   lo_q, lo_d, hi_q, hi_d, mid_q, mid_d;
  logic [HW-1:0]      key_q, key_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic [HW-1:0]      counter_q, counter_d;

  logic [AW-1:0]      res_amount_q, res_amount_d;
  logic [IW-1:0]      res_id_q, res_id_d;
  logic [HW-1:0]      res_removed_q, res_removed_d;
  shidx_pkg::status_e res_status_q, res_status_d;

  logic               out_valid_q, out_valid_d;
  logic [AW-1:0]      out_amount_q, out_amount_d;
  logic [IW-1:0]      out_id_q, out_id_d;
  logic [HW-1:0]      out_total_q, out_total_d;
  logic [HW-1:0]      out_removed_q, out_removed_d;
  shidx_pkg::status_e out_status_q, out_status_d;

  logic               ram_we;
  logic [IDX_W-1:0]   ram_addr;
  logic [EW-1:0]      ram_wdata;
  logic [EW-1:0]      ram_rdata;
  logic [HW-1:0]      rd_height;

  logic [CNT_W-1:0]   lo_n, hi_n, mid_n;
  logic               in_acc;

  // entry ram: {height, amount, id}
  shidx_ram #(
    .WIDTH(EW),
    .DEPTH(TABLE_DEPTH)
  ) u_entry_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .addr_i (ram_addr),
    .wdata_i(ram_wdata),
    .rdata_o(ram_rdata)
  );

  assign rd_height  = ram_rdata[EW-1 -: HW];
  assign in_ready_o = (state_q == shidx_pkg::ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign ram_wdata  = {counter_q, amount_i, token_id_i};

  // one binary search step on the entry read last cycle
  always_comb begin
    lo_n = lo_q;
    hi_n = hi_q;
    if (rd_height <= key_q) begin
      lo_n = mid_q + CNT_W'(1);
    end else begin
      hi_n = mid_q;
    end
    mid_n = lo_n + ((hi_n - lo_n) >> 1);
  end

  // control and next state
  always_comb begin
    state_d       = state_q;
    query_d       = query_q;
    lo_d          = lo_q;
    hi_d          = hi_q;
    mid_d         = mid_q;
    key_d         = key_q;
    count_d       = count_q;
    counter_d     = counter_q;
    res_amount_d  = res_amount_q;
    res_id_d      = res_id_q;
    res_removed_d = res_removed_q;
    res_status_d  = res_status_q;
    ram_we        = 1'b0;
    ram_addr      = count_q[IDX_W-1:0];

    out_valid_d   = out_valid_q && !out_ready_i;
    out_amount_d  = out_amount_q;
    out_id_d      = out_id_q;
    out_total_d   = out_total_q;
    out_removed_d = out_removed_q;
    out_status_d  = out_status_q;

    unique case (state_q)
      shidx_pkg::ST_IDLE: begin
        if (in_acc) begin
          res_amount_d  = '0;
          res_id_d      = '0;
          res_removed_d = '0;
          res_status_d  = shidx_pkg::STAT_OK;
          lo_d          = '0;
          hi_d          = count_q;
          mid_d         = count_q >> 1;
          state_d       = shidx_pkg::ST_DONE;
          unique case (shidx_pkg::mode_e'(mode_i))
            shidx_pkg::MODE_PUSH: begin
              if (counter_q == '1) begin
                res_status_d = shidx_pkg::STAT_OVERFLOW;
              end else if (amount_i != '0 && count_q == CNT_W'(TABLE_DEPTH)) begin
                res_status_d = shidx_pkg::STAT_FULL;
              end else begin
                if (amount_i != '0) begin
                  ram_we  = 1'b1;
                  count_d = count_q + CNT_W'(1);
                end
                counter_d = counter_q + HW'(1);
              end
            end
            shidx_pkg::MODE_POP: begin
              if (counter_q == '0) begin
                res_status_d = shidx_pkg::STAT_POP_EMPTY;
              end else begin
                counter_d = counter_q - HW'(1);
                if (count_q != '0) begin
                  ram_addr = IDX_W'(count_q - CNT_W'(1));
                  state_d  = shidx_pkg::ST_POP;
                end
              end
            end
            shidx_pkg::MODE_TRUNC: begin
              query_d = 1'b0;
              if (height_i < counter_q) begin
                res_removed_d = counter_q - height_i;
                counter_d     = height_i;
                key_d         = height_i - HW'(1);
                if (height_i == '0 || count_q == '0) begin
                  count_d = '0;
                end else begin
                  ram_addr = IDX_W'(count_q >> 1);
                  state_d  = shidx_pkg::ST_SEARCH;
                end
              end
            end
            shidx_pkg::MODE_QUERY: begin
              query_d = 1'b1;
              key_d   = height_i;
              if (counter_q != '0 && count_q != '0) begin
                ram_addr = IDX_W'(count_q >> 1);
                state_d  = shidx_pkg::ST_SEARCH;
              end
            end
            default: ;
          endcase
        end
      end
      shidx_pkg::ST_SEARCH: begin
        lo_d  = lo_n;
        hi_d  = hi_n;
        mid_d = mid_n;
        if (lo_n < hi_n) begin
          ram_addr = mid_n[IDX_W-1:0];
        end else if (!query_q) begin
          count_d = lo_n;
          state_d = shidx_pkg::ST_DONE;
        end else if (lo_n != '0) begin
          ram_addr = IDX_W'(lo_n - CNT_W'(1));
          state_d  = shidx_pkg::ST_FETCH;
        end else begin
          state_d = shidx_pkg::ST_DONE;
        end
      end
      shidx_pkg::ST_FETCH: begin
        res_amount_d = ram_rdata[AW+IW-1:IW];
        res_id_d     = ram_rdata[IW-1:0];
        state_d      = shidx_pkg::ST_DONE;
      end
      shidx_pkg::ST_POP: begin
        // drop the last entry if it sits at the new counter
        if (rd_height == counter_q) begin
          count_d = count_q - CNT_W'(1);
        end
        state_d = shidx_pkg::ST_DONE;
      end
      shidx_pkg::ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d   = 1'b1;
          out_amount_d  = res_amount_q;
          out_id_d      = res_id_q;
          out_total_d   = counter_q;
          out_removed_d = res_removed_q;
          out_status_d  = res_status_q;
          state_d       = shidx_pkg::ST_IDLE;
        end
      end
      default: state_d = shidx_pkg::ST_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= shidx_pkg::ST_IDLE;
      count_q     <= '0;
      counter_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      counter_q   <= counter_d;
      out_valid_q <= out_valid_d;
    end
  end

  // working and payload registers
  always_ff @(posedge clk_i) begin
    query_q       <= query_d;
    lo_q          <= lo_d;
    hi_q          <= hi_d;
    mid_q         <= mid_d;
    key_q         <= key_d;
    res_amount_q  <= res_amount_d;
    res_id_q      <= res_id_d;
    res_removed_q <= res_removed_d;
    res_status_q  <= res_status_d;
    out_amount_q  <= out_amount_d;
    out_id_q      <= out_id_d;
    out_total_q   <= out_total_d;
    out_removed_q <= out_removed_d;
    out_status_q  <= out_status_d;
  end

  assign out_valid_o      = out_valid_q;
  assign found_amount_o   = out_amount_q;
  assign found_token_id_o = out_id_q;
  assign block_total_o    = out_total_q;
  assign removed_blocks_o = out_removed_q;
  assign status_o         = out_status_q;

  // entry count never exceeds the table
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(TABLE_DEPTH))
    else $error("entry count above table depth");

  // a search step always has a nonempty range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == shidx_pkg::ST_SEARCH |-> lo_q < hi_q && mid_q >= lo_q && mid_q < hi_q)
    else $error("binary search range empty");

  // an accepted item blocks the input until it is finished
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !in_ready_o)
    else $error("item accepted while busy");

  // a result is loaded only into a free or draining output register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == shidx_pkg::ST_DONE && out_valid_q && !out_ready_i |=>
      state_q == shidx_pkg::ST_DONE)
    else $error("result overwrote pending output");

endmodule

// ===== sim/tb_top.sv =====
// tb_top: self-checking bench for sparse_height_index_table_core, random and directed items
// depends on shidx_pkg and the core rtl; a scoreboard class tracks the expected table state
`timescale 1ns / 100ps

module tb_top;

  localparam int unsigned DEPTH          = shidx_pkg::TABLE_DEPTH_DEF;
  localparam int unsigned WATCHDOG_LIMIT = 3000;
  localparam int unsigned HOLD_CYCLES    = 400;
  localparam int unsigned DRAIN_CYCLES   = 40;

  // one result of the table as seen on the output ports
  typedef struct packed {
    logic [shidx_pkg::AMOUNT_W-1:0] amount;
    logic [shidx_pkg::ID_W-1:0]     ident;
    logic [shidx_pkg::HEIGHT_W-1:0] total;
    logic [shidx_pkg::HEIGHT_W-1:0] removed;
    shidx_pkg::status_e             status;
  } table_result_t;

  // mirror of the height table; predicts one result per accepted item
  class height_table_tracker;
    bit [shidx_pkg::HEIGHT_W-1:0] hgt_mem[DEPTH];
    bit [shidx_pkg::AMOUNT_W-1:0] amt_mem[DEPTH];
    bit [shidx_pkg::ID_W-1:0]     id_mem[DEPTH];
    int unsigned                  live_entries;
    bit [shidx_pkg::HEIGHT_W-1:0] chain_height;
    table_result_t                pending_results[$];
    int unsigned                  mismatches;

    // entries whose height is at most h, scanned down from the top
    function int unsigned entries_up_to(bit [shidx_pkg::HEIGHT_W-1:0] h);
      int unsigned n;
      n = live_entries;
      while (n > 0 && hgt_mem[n-1] > h) n--;
      return n;
    endfunction

    function void note_item(shidx_pkg::mode_e m, bit [shidx_pkg::HEIGHT_W-1:0] h,
                            bit [shidx_pkg::AMOUNT_W-1:0] amt,
                            bit [shidx_pkg::ID_W-1:0] id);
      table_result_t r;
      int unsigned   n;
      r.amount  = '0;
      r.ident   = '0;
      r.removed = '0;
      r.status  = shidx_pkg::STAT_OK;
      case (m)
        shidx_pkg::MODE_PUSH: begin
          if (chain_height == '1) begin
            r.status = shidx_pkg::STAT_OVERFLOW;
          end else if (amt != 0 && live_entries >= DEPTH) begin
            r.status = shidx_pkg::STAT_FULL;
          end else begin
            if (amt != 0) begin
              hgt_mem[live_entries] = chain_height;
              amt_mem[live_entries] = amt;
              id_mem[live_entries]  = id;
              live_entries++;
            end
            chain_height++;
          end
        end
        shidx_pkg::MODE_POP: begin
          if (chain_height == 0) begin
            r.status = shidx_pkg::STAT_POP_EMPTY;
          end else begin
            chain_height--;
            if (live_entries > 0 && hgt_mem[live_entries-1] == chain_height) live_entries--;
          end
        end
        shidx_pkg::MODE_TRUNC: begin
          if (h < chain_height) begin
            n = live_entries;
            while (n > 0 && hgt_mem[n-1] >= h) n--;
            live_entries = n;
            r.removed    = chain_height - h;
            chain_height = h;
          end
        end
        default: begin
          if (chain_height != 0) begin
            n = entries_up_to(h);
            if (n > 0) begin
              r.amount = amt_mem[n-1];
              r.ident  = id_mem[n-1];
            end
          end
        end
      endcase
      r.total = chain_height;
      pending_results.insert(pending_results.size(), r);
    endfunction

    function void check_result(table_result_t got);
      table_result_t want;
      if (pending_results.size() == 0) begin
        $error("result with no item pending");
        mismatches++;
        return;
      end
      want = pending_results.pop_front();
      if (got.amount !== want.amount) begin
        $error("found_amount: expected %h, got %h", want.amount, got.amount);
        mismatches++;
      end
      if (got.ident !== want.ident) begin
        $error("found_token_id: expected %h, got %h", want.ident, got.ident);
        mismatches++;
      end
      if (got.total !== want.total) begin
        $error("block_total: expected %0d, got %0d", want.total, got.total);
        mismatches++;
      end
      if (got.removed !== want.removed) begin
        $error("removed_blocks: expected %0d, got %0d", want.removed, got.removed);
        mismatches++;
      end
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        mismatches++;
      end
    endfunction
  endclass

  logic                           clk_i;
  logic                           rst_ni           = 1'b0;
  logic                           in_valid_i       = 1'b0;
  logic                           in_ready_o;
  logic [1:0]                     mode_i           = shidx_pkg::MODE_PUSH;
  logic [shidx_pkg::HEIGHT_W-1:0] height_i         = '0;
  logic [shidx_pkg::AMOUNT_W-1:0] amount_i         = '0;
  logic [shidx_pkg::ID_W-1:0]     token_id_i       = '0;
  logic                           out_valid_o;
  logic                           out_ready_i      = 1'b0;
  logic [shidx_pkg::AMOUNT_W-1:0] found_amount_o;
  logic [shidx_pkg::ID_W-1:0]     found_token_id_o;
  logic [shidx_pkg::HEIGHT_W-1:0] block_total_o;
  logic [shidx_pkg::HEIGHT_W-1:0] removed_blocks_o;
  logic [1:0]                     status_o;

  int unsigned tx_idle_pct  = 0;
  int unsigned rx_stall_pct = 0;
  int unsigned hold_left    = 0;

  height_table_tracker sb = new;

  sparse_height_index_table_core dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .mode_i           (mode_i),
    .height_i         (height_i),
    .amount_i         (amount_i),
    .token_id_i       (token_id_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .found_amount_o   (found_amount_o),
    .found_token_id_o (found_token_id_o),
    .block_total_o    (block_total_o),
    .removed_blocks_o (removed_blocks_o),
    .status_o         (status_o)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // monitors on both channels
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) begin
      sb.note_item(shidx_pkg::mode_e'(mode_i), height_i, amount_i, token_id_i);
    end
    if (rst_ni && out_valid_o && out_ready_i) begin
      sb.check_result('{found_amount_o, found_token_id_o, block_total_o, removed_blocks_o,
                        shidx_pkg::status_e'(status_o)});
    end
  end

  // receiver: random stalls, plus a long hold-off on request
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_left != 0) begin
        out_ready_i <= 1'b0;
        hold_left--;
      end else begin
        out_ready_i <= ($urandom_range(0, 99) >= rx_stall_pct);
      end
    end
  end

  // watchdog on cycles with no handshake on either channel
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet = 0;
      else quiet++;
    end
    $display("Mismatches found");
    $finish;
  end

  // offer one item after a random gap and wait until it is taken
  task automatic offer_item(input shidx_pkg::mode_e m,
                            input logic [shidx_pkg::HEIGHT_W-1:0] h,
                            input logic [shidx_pkg::AMOUNT_W-1:0] amt,
                            input logic [shidx_pkg::ID_W-1:0] id);
    int unsigned gap;
    gap = 0;
    while ($urandom_range(0, 99) < tx_idle_pct) gap++;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    mode_i     <= m;
    height_i   <= h;
    amount_i   <= amt;
    token_id_i <= id;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  function automatic logic [shidx_pkg::AMOUNT_W-1:0] pick_amount();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r < 4) return '0;
    if (r == 4) return '1;
    return {$urandom, $urandom};
  endfunction

  function automatic logic [shidx_pkg::ID_W-1:0] pick_ident();
    int unsigned r;
    r = $urandom_range(0, 39);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return {$urandom, $urandom};
  endfunction

  // query heights cluster around the stored range with some extremes
  function automatic logic [shidx_pkg::HEIGHT_W-1:0] pick_query_height();
    logic [shidx_pkg::HEIGHT_W-1:0] top;
    top = sb.chain_height;
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2:       return $urandom;
      default: return $urandom_range(0, top + 2);
    endcase
  endfunction

  // truncate mostly near the top so the table is not wiped every time
  function automatic logic [shidx_pkg::HEIGHT_W-1:0] pick_trunc_height();
    logic [shidx_pkg::HEIGHT_W-1:0] top;
    int unsigned                    r;
    top = sb.chain_height;
    r   = $urandom_range(0, 9);
    if (r < 6) return top - $urandom_range(0, (top < 6) ? top : 6);
    if (r < 8) return $urandom_range(0, top);
    if (r == 8) return $urandom;
    return top + $urandom_range(0, 3);
  endfunction

  task automatic offer_mixed(input int unsigned push_pct, input int unsigned pop_pct,
                             input int unsigned trunc_pct);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < push_pct)
      offer_item(shidx_pkg::MODE_PUSH, $urandom, pick_amount(), pick_ident());
    else if (r < push_pct + pop_pct)
      offer_item(shidx_pkg::MODE_POP, $urandom, pick_amount(), pick_ident());
    else if (r < push_pct + pop_pct + trunc_pct)
      offer_item(shidx_pkg::MODE_TRUNC, pick_trunc_height(), pick_amount(), pick_ident());
    else
      offer_item(shidx_pkg::MODE_QUERY, pick_query_height(), pick_amount(), pick_ident());
  endtask

  task automatic run_directed();
    // empty table: pop underflow, queries and truncate with no blocks
    offer_item(shidx_pkg::MODE_POP,   '0, '0, '0);
    offer_item(shidx_pkg::MODE_QUERY, '0, '1, '1);
    offer_item(shidx_pkg::MODE_QUERY, '1, '0, '0);
    offer_item(shidx_pkg::MODE_TRUNC, '0, '0, '0);
    // heights 0..4: entries only at 1, 2 and 4
    offer_item(shidx_pkg::MODE_PUSH,  '0, '0, 64'h1234_5678_9abc_def0);
    offer_item(shidx_pkg::MODE_PUSH,  '1, '1, '1);
    offer_item(shidx_pkg::MODE_PUSH,  '0, 64'd1, '0);
    offer_item(shidx_pkg::MODE_PUSH,  '0, '0, '1);
    offer_item(shidx_pkg::MODE_PUSH,  '0, 64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555);
    // query below the first entry, on entries, between entries, at the top
    offer_item(shidx_pkg::MODE_QUERY, 32'd0, '0, '0);
    offer_item(shidx_pkg::MODE_QUERY, 32'd1, '0, '0);
    offer_item(shidx_pkg::MODE_QUERY, 32'd3, '0, '0);
    offer_item(shidx_pkg::MODE_QUERY, '1, '0, '0);
    // pop dropping an entry, then pop over a block with no entry
    offer_item(shidx_pkg::MODE_POP,   '0, '0, '0);
    offer_item(shidx_pkg::MODE_POP,   '0, '0, '0);
    // truncate above and at the counter changes nothing
    offer_item(shidx_pkg::MODE_TRUNC, 32'd10, '0, '0);
    offer_item(shidx_pkg::MODE_TRUNC, 32'd3, '0, '0);
    // truncate below the counter, then down to zero
    offer_item(shidx_pkg::MODE_TRUNC, 32'd2, '0, '0);
    offer_item(shidx_pkg::MODE_QUERY, 32'd5, '0, '0);
    offer_item(shidx_pkg::MODE_TRUNC, 32'd0, '0, '0);
    offer_item(shidx_pkg::MODE_POP,   '0, '0, '0);
    offer_item(shidx_pkg::MODE_QUERY, 32'd0, '0, '0);
    offer_item(shidx_pkg::MODE_PUSH,  '0, 64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa);
    offer_item(shidx_pkg::MODE_QUERY, 32'd0, '0, '0);
  endtask

  // push until the table is full, then work at the full boundary
  task automatic run_fill();
    int unsigned k;
    while (sb.live_entries < DEPTH) begin
      if ($urandom_range(0, 9) == 0)
        offer_item(shidx_pkg::MODE_QUERY, pick_query_height(), pick_amount(), pick_ident());
      else
        offer_item(shidx_pkg::MODE_PUSH, $urandom, {$urandom, $urandom} | 64'd1,
                   pick_ident());
    end
    for (k = 0; k < 16; k++) begin
      case (k % 4)
        0: offer_item(shidx_pkg::MODE_PUSH, $urandom, {$urandom, $urandom} | 64'd1,
                      pick_ident());
        1: offer_item(shidx_pkg::MODE_PUSH, $urandom, '0, pick_ident());
        2: offer_item(shidx_pkg::MODE_QUERY, pick_query_height(), pick_amount(),
                      pick_ident());
        default: offer_item(shidx_pkg::MODE_POP, $urandom, pick_amount(), pick_ident());
      endcase
    end
  endtask

  // main sequence
  initial begin
    int unsigned i;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    run_directed();

    // no idling, with one long receiver hold-off
    for (i = 0; i < 60; i++) begin
      if (i == 40) hold_left = HOLD_CYCLES;
      offer_mixed(50, 15, 6);
    end

    // sender idle while the table fills up
    tx_idle_pct  = 64;
    rx_stall_pct = 0;
    run_fill();

    // receiver stalling, truncates shrink the full table
    tx_idle_pct  = 0;
    rx_stall_pct = 64;
    for (i = 0; i < 60; i++) offer_mixed(45, 15, 10);

    // both sides idle
    tx_idle_pct  = 36;
    rx_stall_pct = 36;
    for (i = 0; i < 60; i++) offer_mixed(50, 15, 6);

    in_valid_i <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (sb.mismatches == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
